// ===== rtl/lsgd_pkg.sv =====
// Package for the line sensor gray detector: constants, queue item and state types.
// It has no dependencies. Every other file of the block imports it.
package lsgd_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int FRAC_BITS     = 16;
    localparam int LEVEL_W       = FRAC_BITS + 1;
    localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int DIV_CNT_W     = $clog2(FRAC_BITS);
    localparam int SAMPLE_W      = 10;
    localparam int TIME_W        = 32;
    localparam int HOLD_W        = 16;
    localparam int COUNT_W       = 12;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = LEVEL_W;

    localparam logic [LEVEL_W-1:0] ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [SAMPLE_W-1:0] TOP_RESET     = SAMPLE_W'(307);
    localparam logic [SAMPLE_W-1:0] BOTTOM_RESET  = SAMPLE_W'(102);
    localparam logic [LEVEL_W-1:0]  BAND_RESET    = LEVEL_W'(1966);
    localparam logic [LEVEL_W-1:0]  RISE_RESET    = LEVEL_W'(3277);
    localparam logic [COUNT_W-1:0]  SAMPLES_RESET = COUNT_W'(500);
    localparam logic [HOLD_W-1:0]   HOLD_RESET    = HOLD_W'(1000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_TOP       = 3'd0,
        CFG_LINE_BOTTOM    = 3'd1,
        CFG_STABLE_BAND    = 3'd2,
        CFG_RISE_THRESHOLD = 3'd3,
        CFG_STABLE_SAMPLES = 3'd4,
        CFG_HOLD_MS        = 3'd5
    } lsgd_cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] line_top;
        logic [SAMPLE_W-1:0] line_bottom;
        logic [LEVEL_W-1:0]  stable_band;
        logic [LEVEL_W-1:0]  rise_threshold;
        logic [COUNT_W-1:0]  stable_samples;
        logic [HOLD_W-1:0]   hold_ms;
    } lsgd_cfg_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_DIVIDE
    } lsgd_kind_t;

    typedef struct packed {
        lsgd_kind_t          kind;
        logic [SAMPLE_W-1:0] num;
        logic [SAMPLE_W-1:0] den;
        logic [TIME_W-1:0]   time_ms;
    } lsgd_task_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_UPDATE
    } lsgd_back_state_t;

endpackage

// ===== rtl/lsgd_stream_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on lsgd_pkg for the field widths.
interface lsgd_in_if import lsgd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output sample, output time_ms, input ready);
    modport sink (input valid, input sample, input time_ms, output ready);
endinterface

interface lsgd_out_if import lsgd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               gray_found;
    logic               armed;

    modport source (output valid, output level, output gray_found, output armed,
                    input ready);
    modport sink (input valid, input level, input gray_found, input armed,
                  output ready);
endinterface

// ===== rtl/line_sensor_gray_detector_core.sv =====
// Top level of the line sensor gray detector: configuration registers and wiring.
// Depends on lsgd_pkg, lsgd_stream_if, lsgd_front, lsgd_queue and lsgd_back.
//
// Each input item carries a 10-bit light sample and a millisecond timestamp; each
// yields exactly one result item with the Q1.16 level, the gray flag and the armed
// flag. Both channels use valid/ready and an item moves when both are high.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// do so only while no item is in flight, as the block does not enforce it.
// Indexes six and seven are ignored. A sample that lands strictly between bottom
// and top goes through a serial divider that produces one quotient bit per cycle,
// so the back end takes the task, runs 16 divide steps and then the update.
// Samples that clamp to zero or one go from taking the task straight to the update.
// A two-entry queue lets the front end keep accepting items while the divider
// works, and the result register lets the back end start the next item while a
// result waits on a stalled receiver.
// Reset clears the history ring, the stability state, the queue and the result
// valid, gray and armed flags, and restores the default calibration.
module line_sensor_gray_detector_core import lsgd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    lsgd_in_if.sink                in,
    lsgd_out_if.source             out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    lsgd_cfg_t  cfg_reg;
    lsgd_cfg_t  cfg_next;
    logic       push_valid;
    logic       push_ready;
    lsgd_task_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    lsgd_task_t pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_TOP:       cfg_next.line_top       = cfg_data[SAMPLE_W-1:0];
                CFG_LINE_BOTTOM:    cfg_next.line_bottom    = cfg_data[SAMPLE_W-1:0];
                CFG_STABLE_BAND:    cfg_next.stable_band    = cfg_data[LEVEL_W-1:0];
                CFG_RISE_THRESHOLD: cfg_next.rise_threshold = cfg_data[LEVEL_W-1:0];
                CFG_STABLE_SAMPLES: cfg_next.stable_samples = cfg_data[COUNT_W-1:0];
                CFG_HOLD_MS:        cfg_next.hold_ms        = cfg_data[HOLD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_top       <= TOP_RESET;
            cfg_reg.line_bottom    <= BOTTOM_RESET;
            cfg_reg.stable_band    <= BAND_RESET;
            cfg_reg.rise_threshold <= RISE_RESET;
            cfg_reg.stable_samples <= SAMPLES_RESET;
            cfg_reg.hold_ms        <= HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsgd_front u_front (
        .in         (in),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lsgd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lsgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out       (out)
    );

    // An accepted item is waiting in the queue on the next cycle.
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready) |=> pop_valid)
        else $error("accepted item missing from queue");

    // The normalized level never exceeds one.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> (out.level <= ONE_Q))
        else $error("result level above full scale");

    // A new result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> $stable(out.level))
        else $error("pending result overwritten");

endmodule

// ===== rtl/lsgd_front.sv =====
// Front end: accepts input items and sorts each into a zero, full-scale or divide task.
// Depends on lsgd_pkg and lsgd_in_if.
module lsgd_front import lsgd_pkg::*; (
    lsgd_in_if.sink          in,
    input  lsgd_cfg_t        cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output lsgd_task_t       push_data
);

    logic signed [SAMPLE_W:0] num_raw;
    logic signed [SAMPLE_W:0] den_raw;
    logic signed [SAMPLE_W:0] num_abs;
    logic signed [SAMPLE_W:0] den_abs;

    assign num_raw = $signed({1'b0, in.sample}) - $signed({1'b0, cfg.line_bottom});
    assign den_raw = $signed({1'b0, cfg.line_top}) - $signed({1'b0, cfg.line_bottom});

    always_comb
    begin
        if (den_raw < 0)
        begin
            num_abs = -num_raw;
            den_abs = -den_raw;
        end
        else
        begin
            num_abs = num_raw;
            den_abs = den_raw;
        end
    end

    always_comb
    begin
        push_data.num     = num_abs[SAMPLE_W-1:0];
        push_data.den     = den_abs[SAMPLE_W-1:0];
        push_data.time_ms = in.time_ms;
        if (den_raw == 0 || num_abs <= 0)
        begin
            push_data.kind = KIND_ZERO;
        end
        else if (num_abs >= den_abs)
        begin
            push_data.kind = KIND_ONE;
        end
        else
        begin
            push_data.kind = KIND_DIVIDE;
        end
    end

    assign push_valid = in.valid;
    assign in.ready   = push_ready;

endmodule

// ===== rtl/lsgd_queue.sv =====
// Short task queue that decouples the front end from the back end.
// Depends on lsgd_pkg for the task type and depth.
module lsgd_queue import lsgd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  lsgd_task_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output lsgd_task_t pop_data
);

    lsgd_task_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_W-1:0] wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg;
    logic [QUEUE_IDX_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/lsgd_back.sv =====
// Back end: serial divider, history ring, stability counter, gray detection
// and the result register. Depends on lsgd_pkg and lsgd_out_if.
module lsgd_back import lsgd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  lsgd_cfg_t   cfg,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  lsgd_task_t  pop_data,
    lsgd_out_if.source  out
);

    lsgd_back_state_t state_reg;
    lsgd_back_state_t state_next;

    logic [LEVEL_W-1:0]    level_reg;
    logic [LEVEL_W-1:0]    level_next;
    logic [SAMPLE_W-1:0]   rem_reg;
    logic [SAMPLE_W-1:0]   rem_next;
    logic [SAMPLE_W-1:0]   den_reg;
    logic [SAMPLE_W-1:0]   den_next;
    logic [DIV_CNT_W-1:0]  step_reg;
    logic [DIV_CNT_W-1:0]  step_next;
    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     time_next;

    logic [LEVEL_W-1:0]    hist_reg [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] wpos_reg;
    logic [HIST_IDX_W-1:0] wpos_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [TIME_W-1:0]     found_reg;
    logic [TIME_W-1:0]     found_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [LEVEL_W-1:0]    out_level_reg;
    logic                  out_gray_reg;
    logic                  out_gray_next;
    logic                  out_armed_reg;

    logic                  take;
    logic                  div_step;
    logic                  commit;
    logic                  out_free;
    logic                  div_last;

    logic [SAMPLE_W:0]         rem_shift;
    logic                      rem_ge;
    logic [LEVEL_W-1:0]        old_level;
    logic signed [LEVEL_W:0]   diff;
    logic signed [LEVEL_W:0]   diff_abs;
    logic [LEVEL_W-1:0]        mag;
    logic [TIME_W-1:0]         elapsed;
    logic [TIME_W-1:0]         hold_ext;
    logic                      flag_mid;

    assign out_free = !out_valid_reg || out.ready;
    assign div_last = (step_reg == DIV_CNT_W'(FRAC_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (pop_data.kind == KIND_DIVIDE) ? BK_DIV : BK_UPDATE;
                end
            end
            BK_DIV:
            begin
                if (div_last)
                begin
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        div_step  = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            BK_IDLE:   pop_ready = 1'b1;
            BK_DIV:    div_step  = 1'b1;
            BK_UPDATE: commit    = out_free;
            default:   pop_ready = 1'b0;
        endcase
    end

    assign take = pop_valid && pop_ready;

    // One quotient bit per cycle; during a division the remainder stays below the divisor.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        level_next = level_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        step_next  = step_reg;
        time_next  = time_reg;
        if (take)
        begin
            level_next = (pop_data.kind == KIND_ONE) ? ONE_Q : '0;
            rem_next   = pop_data.num;
            den_next   = pop_data.den;
            step_next  = '0;
            time_next  = pop_data.time_ms;
        end
        else if (div_step)
        begin
            level_next = {level_reg[LEVEL_W-2:0], rem_ge};
            rem_next   = rem_ge ? SAMPLE_W'(rem_shift - {1'b0, den_reg})
                                : rem_shift[SAMPLE_W-1:0];
            step_next  = step_reg + 1'b1;
        end
    end

    assign old_level = hist_reg[(wpos_reg == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                : wpos_reg + 1'b1];
    assign diff      = $signed({1'b0, level_reg}) - $signed({1'b0, old_level});
    assign diff_abs  = (diff < 0) ? -diff : diff;
    assign mag       = diff_abs[LEVEL_W-1:0];
    assign elapsed   = time_reg - found_reg;
    assign hold_ext  = {{(TIME_W - HOLD_W){1'b0}}, cfg.hold_ms};

    always_comb
    begin
        count_next    = count_reg;
        flag_mid      = flag_reg;
        flag_next     = flag_reg;
        found_next    = found_reg;
        out_gray_next = out_gray_reg;
        wpos_next     = wpos_reg;
        if (commit)
        begin
            if (!flag_reg && mag <= cfg.stable_band)
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (count_next > cfg.stable_samples)
                begin
                    flag_mid = 1'b1;
                end
            end
            else
            begin
                count_next = '0;
            end
            flag_next = flag_mid;
            if (elapsed > hold_ext && flag_mid
                && diff > $signed({1'b0, cfg.rise_threshold}))
            begin
                found_next    = time_reg;
                out_gray_next = 1'b1;
                flag_next     = 1'b0;
            end
            else
            begin
                out_gray_next = (elapsed < hold_ext);
            end
            wpos_next = (wpos_reg == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0
                        : wpos_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wpos_reg      <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_gray_reg  <= 1'b0;
            out_armed_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_gray_reg  <= out_gray_next;
            if (commit)
            begin
                hist_reg[wpos_reg] <= level_reg;
                out_armed_reg      <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        step_reg  <= step_next;
        time_reg  <= time_next;
        if (commit)
        begin
            out_level_reg <= level_reg;
        end
    end

    assign out.valid      = out_valid_reg;
    assign out.level      = out_level_reg;
    assign out.gray_found = out_gray_reg;
    assign out.armed      = out_armed_reg;

endmodule

// ===== tb/sv/lsgd_result_checker.sv =====
// Result checker for the line sensor gray detector: watches both item channels and
// the register port, predicts each result and compares it with the block's output.
// Depends on lsgd_pkg and the channel interfaces in lsgd_stream_if.
module lsgd_result_checker import lsgd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    lsgd_in_if                     in_ch,
    lsgd_out_if                    out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               gray;
        logic               armed;
    } reading_t;

    logic [SAMPLE_W-1:0]   white_lvl;
    logic [SAMPLE_W-1:0]   black_lvl;
    logic [LEVEL_W-1:0]    band;
    logic [LEVEL_W-1:0]    rise;
    logic [COUNT_W-1:0]    need_count;
    logic [HOLD_W-1:0]     hold;

    logic [LEVEL_W-1:0]    ring [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] ring_pos;
    logic [COUNT_W-1:0]    steady_run;
    logic                  steady;
    logic [TIME_W-1:0]     last_find;

    reading_t              expected_q [$];
    reading_t              want;
    reading_t              got;

    function automatic logic [LEVEL_W-1:0] scaled_level(input logic [SAMPLE_W-1:0] s);
        longint num;
        longint den;
        longint q;
        num = longint'(s) - longint'(black_lvl);
        den = longint'(white_lvl) - longint'(black_lvl);
        if (den == 0)
            return '0;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return '0;
        q = (num << FRAC_BITS) / den;
        if (q > longint'(ONE_Q))
            q = longint'(ONE_Q);
        return LEVEL_W'(q);
    endfunction

    function automatic reading_t advance_detector(input logic [SAMPLE_W-1:0] s,
                                                  input logic [TIME_W-1:0] now);
        reading_t              r;
        logic [HIST_IDX_W-1:0] oldest;
        logic [TIME_W-1:0]     elapsed;
        longint                diff;
        longint                mag;
        r.level = scaled_level(s);
        oldest = ring_pos + 1'b1;
        ring[ring_pos] = r.level;
        diff = longint'(r.level) - longint'(ring[oldest]);
        mag = (diff < 0) ? -diff : diff;
        if (!steady && mag <= longint'(band))
        begin
            if (steady_run != COUNT_MAX)
                steady_run = steady_run + 1'b1;
            if (steady_run > need_count)
                steady = 1'b1;
        end
        else
            steady_run = '0;
        elapsed = now - last_find;
        if (elapsed > TIME_W'(hold) && steady && diff > longint'(rise))
        begin
            last_find = now;
            r.gray = 1'b1;
            steady = 1'b0;
        end
        else
            r.gray = (elapsed < TIME_W'(hold));
        ring_pos = ring_pos + 1'b1;
        r.armed = steady;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_lvl = TOP_RESET;
            black_lvl = BOTTOM_RESET;
            band = BAND_RESET;
            rise = RISE_RESET;
            need_count = SAMPLES_RESET;
            hold = HOLD_RESET;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                ring[i] = '0;
            ring_pos = '0;
            steady_run = '0;
            steady = 1'b0;
            last_find = '0;
            expected_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.level = out_ch.level;
                got.gray = out_ch.gray_found;
                got.armed = out_ch.armed;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result item: level %0d gray %0d armed %0d",
                             $time, got.level, got.gray, got.armed);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch: expected level %0d gray %0d armed %0d, %s",
                                 $time, want.level, want.gray, want.armed,
                                 $sformatf("actual level %0d gray %0d armed %0d",
                                           got.level, got.gray, got.armed));
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(advance_detector(in_ch.sample, in_ch.time_ms));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINE_TOP:       white_lvl = cfg_data[SAMPLE_W-1:0];
                    CFG_LINE_BOTTOM:    black_lvl = cfg_data[SAMPLE_W-1:0];
                    CFG_STABLE_BAND:    band = cfg_data[LEVEL_W-1:0];
                    CFG_RISE_THRESHOLD: rise = cfg_data[LEVEL_W-1:0];
                    CFG_STABLE_SAMPLES: need_count = cfg_data[COUNT_W-1:0];
                    CFG_HOLD_MS:        hold = cfg_data[HOLD_W-1:0];
                    default:            ;
                endcase
            end
            pending_count = expected_q.size();
        end
    end

endmodule

// ===== tb/sv/line_sensor_gray_detector_core_tb.sv =====
// Top of the line sensor gray detector testbench: clock, reset, register writes,
// directed and random sample streams with random stalls, and the final verdict.
// Depends on lsgd_pkg, lsgd_stream_if, the block and lsgd_result_checker.
module line_sensor_gray_detector_core_tb;
    import lsgd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 90;
    localparam int SAT_ITEMS    = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending_count;
    int                     cycles = 0;
    bit                     idle_on;
    int                     items_sent = 0;
    int                     cur_top;
    int                     cur_bottom;
    int                     cur_need;
    int                     cur_hold;
    logic [TIME_W-1:0]      now_ms;

    lsgd_in_if  in_ch ();
    lsgd_out_if out_ch ();

    line_sensor_gray_detector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lsgd_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("line_sensor_gray_detector_core regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready = !idle_on || ($urandom_range(99) >= 20);

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_calibration(input int t, input int b, input int band, input int rise,
                                   input int need, input int hold);
        write_reg(CFG_LINE_TOP, CFG_DATA_W'(t));
        write_reg(CFG_LINE_BOTTOM, CFG_DATA_W'(b));
        write_reg(CFG_STABLE_BAND, CFG_DATA_W'(band));
        write_reg(CFG_RISE_THRESHOLD, CFG_DATA_W'(rise));
        write_reg(CFG_STABLE_SAMPLES, CFG_DATA_W'(need));
        write_reg(CFG_HOLD_MS, CFG_DATA_W'(hold));
        cur_top = t;
        cur_bottom = b;
        cur_need = need;
        cur_hold = hold;
    endtask

    task automatic send_sample(input int s, input logic [TIME_W-1:0] t);
        while (idle_on && $urandom_range(99) < 20)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.sample = SAMPLE_W'(s);
        in_ch.time_ms = t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int random_start;
        int phase_start;
        int kind;
        int lo_b;
        int hi_b;
        int a;
        int b;
        int lo_s;
        int hi_s;
        int s;
        int run_len;
        int rise_len;
        int break_at;
        int step_max;
        int t_sel;
        int b_sel;
        int band;
        int rise;
        int need;
        int hold;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LINE_TOP;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.time_ms = '0;
        out_ch.ready = 1'b0;
        idle_on = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset calibration: spare index writes, extremes of the sample, the hold boundary and a time wrap.
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        send_sample(0, 32'd0);
        send_sample(1023, 32'd999);
        send_sample(102, 32'd1000);
        send_sample(307, 32'd1001);
        send_sample(103, 32'hFFFF_FFFF);
        send_sample(306, 32'h8000_0000);
        send_sample(204, 32'd5);
        send_sample(101, 32'h7FFF_FFFF);
        wait_for_results();

        // Equal top and bottom.
        set_calibration(500, 500, 1966, 3277, 500, 1000);
        send_sample(500, 32'd2000);
        send_sample(1023, 32'd2001);
        send_sample(0, 32'd2002);
        wait_for_results();

        // Top below bottom.
        set_calibration(100, 900, 0, 0, 0, 0);
        send_sample(900, 32'd3000);
        send_sample(1000, 32'd3001);
        send_sample(100, 32'd3002);
        send_sample(0, 32'd3003);
        send_sample(500, 32'd3004);
        wait_for_results();

        // Full range, with register data wider than the register.
        set_calibration(1023, 0, 65536, 0, 0, 0);
        write_reg(CFG_LINE_TOP, 17'h1FFFF);
        write_reg(CFG_LINE_BOTTOM, 17'h1FC00);
        send_sample(0, 32'd4000);
        send_sample(1023, 32'd4001);
        send_sample(512, 32'd4001);
        send_sample(1, 32'd4002);
        send_sample(1022, 32'd4003);
        wait_for_results();

        // With the largest count required, a steady stream does not arm detection.
        idle_on = 1'b0;
        set_calibration(307, 102, 0, 0, 4095, 0);
        now_ms = 32'd10_000;
        repeat (SAT_ITEMS)
        begin
            send_sample(0, now_ms);
            now_ms += 1;
        end
        wait_for_results();
        write_reg(CFG_STABLE_SAMPLES, CFG_DATA_W'(4094));
        cur_need = 4094;
        send_sample(0, now_ms);
        send_sample(0, now_ms + 1);
        send_sample(307, now_ms + 2);
        send_sample(307, now_ms + 3);
        wait_for_results();
        idle_on = 1'b1;

        phase = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            idle_on = (phase != 2);
            t_sel = $urandom_range(5);
            case (t_sel)
                0:
                begin
                    a = 1023;
                    b = 0;
                end
                1:
                begin
                    a = $urandom_range(1023);
                    b = a;
                end
                2:
                begin
                    b = $urandom_range(100, 1023);
                    a = $urandom_range(b - 50, 0);
                end
                default:
                begin
                    b = $urandom_range(600);
                    a = $urandom_range(1023, b + 50);
                end
            endcase
            b_sel = $urandom_range(9);
            band = (b_sel == 0) ? 0 : (b_sel == 1) ? 65536 : $urandom_range(4000);
            b_sel = $urandom_range(9);
            rise = (b_sel == 0) ? 0 : (b_sel == 1) ? 65536 : $urandom_range(500, 30000);
            b_sel = $urandom_range(9);
            need = (b_sel == 0) ? 0 : (b_sel == 1) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            b_sel = $urandom_range(9);
            hold = (b_sel == 0) ? 0 : (b_sel == 1) ? 65535 : $urandom_range(1, 80);
            set_calibration(a, b, band, rise, need, hold);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
            now_ms = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - TIME_W'($urandom_range(300))
                                              : TIME_W'($urandom);
            step_max = cur_hold / 8 + 2;
            lo_b = (cur_top < cur_bottom) ? cur_top : cur_bottom;
            hi_b = (cur_top < cur_bottom) ? cur_bottom : cur_top;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                kind = $urandom_range(99);
                if (kind < 75)
                begin
                    // A steady stretch long enough to arm, sometimes broken, then a step toward white.
                    a = $urandom_range(lo_b, hi_b);
                    b = $urandom_range(lo_b, hi_b);
                    if (a > b)
                    begin
                        s = a;
                        a = b;
                        b = s;
                    end
                    if (cur_top >= cur_bottom)
                    begin
                        lo_s = a;
                        hi_s = ($urandom_range(5) == 0) ? $urandom_range(hi_b, 1023) : b;
                    end
                    else
                    begin
                        lo_s = b;
                        hi_s = ($urandom_range(5) == 0) ? $urandom_range(lo_b, 0) : a;
                    end
                    run_len = cur_need + 16 + $urandom_range(4);
                    break_at = (kind < 12) ? $urandom_range(run_len - 1) : -1;
                    for (int k = 0; k < run_len; k++)
                    begin
                        s = lo_s;
                        if ($urandom_range(7) == 0)
                            s = $urandom_range(1) ? ((s < 1023) ? s + 1 : s) : ((s > 0) ? s - 1 : s);
                        if (k == break_at)
                            s = $urandom_range(1023);
                        send_sample(s, now_ms);
                        now_ms += TIME_W'($urandom_range(step_max));
                    end
                    rise_len = $urandom_range(1, 18);
                    repeat (rise_len)
                    begin
                        send_sample(hi_s, now_ms);
                        now_ms += TIME_W'($urandom_range(step_max));
                    end
                end
                else
                begin
                    send_sample($urandom_range(1023),
                                ($urandom_range(3) == 0) ? TIME_W'($urandom) : now_ms);
                    now_ms += TIME_W'($urandom_range(step_max));
                end
            end
            wait_for_results();
            phase++;
        end

        idle_on = 1'b1;
        wait_for_results();
        if (fail_count == 0 && pending_count == 0)
            $display("line_sensor_gray_detector_core regression: pass");
        else
            $display("line_sensor_gray_detector_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lsgd_pkg.sv
rtl/lsgd_stream_if.sv
rtl/lsgd_front.sv
rtl/lsgd_queue.sv
rtl/lsgd_back.sv
rtl/line_sensor_gray_detector_core.sv
tb/sv/lsgd_result_checker.sv
tb/sv/line_sensor_gray_detector_core_tb.sv
